// ===== design/sawbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawbs_pkg
// Shared types and constants of the stop-and-wait block sender.
// ----------------------------------------------------------------------------
package sawbs_pkg;

  // largest payload of one block
  localparam int unsigned BLOCK_BYTES = 64;

  localparam int unsigned IMG_W   = 22;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned BD_W    = 23;
  localparam int unsigned OLEN_W  = 7;
  localparam int unsigned LEN_W   = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);

  localparam logic [ID_W-1:0]  END_ID        = 16'hFFFF;
  localparam logic [ID_W-1:0]  ACK_LEN_VALID = 16'd2;
  localparam logic [IMG_W-1:0] IMAGE_RESET   = 22'd129760;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd256;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE   = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_BYTE  = 2'd2,
    MODE_START = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_FETCH  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_END    = 2'd2,
    KIND_NOTICE = 2'd3
  } kind_e;

  typedef struct packed {
    mode_e            mode;
    logic [ID_W-1:0]  ack_id;
    logic [15:0]      ack_length;
    logic [7:0]       payload_byte;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   block_number;
    logic [IMG_W-1:0]  byte_offset;
    logic [OLEN_W-1:0] block_length;
    logic [SUM_W-1:0]  block_sum;
  } out_item_t;

  // classified request between front and back; arg is ack id or payload byte
  typedef struct packed {
    mode_e           op;
    logic [ID_W-1:0] arg;
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/sawbs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawbs_front
// Input side: accepts requests, drops malformed acknowledgements, and
// packs the rest into commands for the queue.
// ----------------------------------------------------------------------------
module sawbs_front (
  input  wire                 in_valid_i,
  input  sawbs_pkg::in_item_t in_data_i,
  output logic                in_stall_o,
  input  wire                 q_full_i,
  output logic                push_o,
  output sawbs_pkg::cmd_t     push_data_o
);
  import sawbs_pkg::*;

  logic keep;

  // only 2-byte acknowledgements carry meaning
  always_comb begin
    keep = 1'b1;
    if (in_data_i.mode == MODE_ACK && in_data_i.ack_length != ACK_LEN_VALID) begin
      keep = 1'b0;
    end
  end

  assign in_stall_o       = q_full_i;
  assign push_o           = in_valid_i && !q_full_i && keep;
  assign push_data_o.op   = in_data_i.mode;
  assign push_data_o.arg  = (in_data_i.mode == MODE_BYTE) ?
                            {{(ID_W-8){1'b0}}, in_data_i.payload_byte} :
                            in_data_i.ack_id;

endmodule
`default_nettype wire

// ===== design/sawbs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawbs_queue
// Small command FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module sawbs_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  sawbs_pkg::cmd_t    push_data_i,
  output logic               full_o,
  output logic               pop_valid_o,
  output sawbs_pkg::cmd_t    pop_data_o,
  input  wire                pop_i
);
  import sawbs_pkg::*;

  cmd_t              mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign full_o      = (count_q == QCNT_W'(Q_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(Q_DEPTH))
    else $error("queue count out of range");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count not advanced on push");

endmodule
`default_nettype wire

// ===== design/sawbs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawbs_back
// Execution side: transfer state, checksum, retransmit timer and the
// registered result stage.
// ----------------------------------------------------------------------------
module sawbs_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire [sawbs_pkg::IMG_W-1:0]       image_bytes_i,
  input  wire [sawbs_pkg::TICK_W-1:0]      timeout_ticks_i,
  input  wire                              q_valid_i,
  input  sawbs_pkg::cmd_t                  q_data_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  output sawbs_pkg::out_item_t             out_data_o,
  input  wire                              out_stall_i
);
  import sawbs_pkg::*;

  logic [ID_W-1:0]   next_block_q, next_block_d;
  logic [BD_W-1:0]   bytes_done_q, bytes_done_d;
  logic              awaiting_q, awaiting_d;
  logic              collecting_q, collecting_d;
  logic [LEN_W-1:0]  collected_q, collected_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              issue;
  logic [BD_W-1:0]   image_ext;
  logic [BD_W-1:0]   rem;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  coll_inc;
  logic [SUM_W-1:0]  sum_inc;
  logic              ack_match;
  logic              do_req;
  logic [BD_W-1:0]   req_bd;
  logic [ID_W-1:0]   req_nb;
  logic [BD_W-1:0]   req_rem;
  logic              req_done;
  logic [LEN_W-1:0]  req_len;
  logic              emit;
  out_item_t         res;

  assign issue   = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = issue;

  assign image_ext = {1'b0, image_bytes_i};
  assign rem       = image_ext - bytes_done_q;
  always_comb begin
    if (bytes_done_q >= image_ext) begin
      cur_len = '0;
    end else if (rem < BD_W'(BLOCK_BYTES)) begin
      cur_len = rem[LEN_W-1:0];
    end else begin
      cur_len = LEN_W'(BLOCK_BYTES);
    end
  end

  assign coll_inc  = collected_q + 1'b1;
  assign sum_inc   = sum_q + {{(SUM_W-8){1'b0}}, q_data_i.arg[7:0]};
  assign ack_match = (awaiting_q || collecting_q) && (q_data_i.arg == next_block_q);

  // length of the block that a fetch would ask for
  assign req_rem = image_ext - req_bd;
  always_comb begin
    req_done = (req_bd >= image_ext);
    if (req_done) begin
      req_len = '0;
    end else if (req_rem < BD_W'(BLOCK_BYTES)) begin
      req_len = req_rem[LEN_W-1:0];
    end else begin
      req_len = LEN_W'(BLOCK_BYTES);
    end
  end

  // request decode: where the new fetch starts from
  always_comb begin
    do_req = 1'b0;
    req_bd = bytes_done_q;
    req_nb = next_block_q;
    unique case (q_data_i.op)
      MODE_START: begin
        do_req = 1'b1;
        req_bd = '0;
        req_nb = '0;
      end
      MODE_TICK: begin
        do_req = awaiting_q && (ticks_q <= TICK_W'(1));
      end
      MODE_ACK: begin
        do_req = ack_match;
        req_bd = bytes_done_q + {{(BD_W-LEN_W){1'b0}}, cur_len};
        req_nb = next_block_q + 1'b1;
      end
      MODE_BYTE: begin
        do_req = 1'b0;
      end
      default: begin
        do_req = 1'b0;
      end
    endcase
  end

  always_comb begin
    next_block_d = next_block_q;
    bytes_done_d = bytes_done_q;
    awaiting_d   = awaiting_q;
    collecting_d = collecting_q;
    collected_d  = collected_q;
    sum_d        = sum_q;
    ticks_d      = ticks_q;
    emit         = 1'b0;
    res          = '{kind: KIND_FETCH, block_number: '0, byte_offset: '0,
                     block_length: '0, block_sum: '0};

    if (issue) begin
      if (do_req) begin
        next_block_d = req_nb;
        bytes_done_d = req_bd;
        awaiting_d   = 1'b0;
        collected_d  = '0;
        sum_d        = '0;
        collecting_d = !req_done;
        emit         = 1'b1;
        if (q_data_i.op != MODE_START) begin
          ticks_d = '0;
        end
        if (req_done) begin
          res.kind         = KIND_END;
          res.block_number = END_ID;
        end else begin
          res.kind         = KIND_FETCH;
          res.block_number = req_nb;
          res.byte_offset  = req_bd[IMG_W-1:0];
          res.block_length = OLEN_W'(req_len);
        end
      end else begin
        case (q_data_i.op)
          MODE_BYTE: begin
            if (collecting_q) begin
              sum_d       = sum_inc;
              collected_d = coll_inc;
              if (coll_inc >= cur_len) begin
                collecting_d     = 1'b0;
                awaiting_d       = 1'b1;
                ticks_d          = timeout_ticks_i;
                emit             = 1'b1;
                res.kind         = KIND_HEADER;
                res.block_number = next_block_q;
                res.byte_offset  = bytes_done_q[IMG_W-1:0];
                res.block_length = OLEN_W'(coll_inc);
                res.block_sum    = sum_inc;
              end
            end
          end
          MODE_TICK: begin
            if (awaiting_q) begin
              ticks_d = ticks_q - 1'b1;
            end
          end
          MODE_ACK: begin
            if (q_data_i.arg == END_ID) begin
              emit             = 1'b1;
              res.kind         = KIND_NOTICE;
              res.block_number = END_ID;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (issue && emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_block_q <= '0;
      bytes_done_q <= '0;
      awaiting_q   <= 1'b0;
      collecting_q <= 1'b0;
      collected_q  <= '0;
      sum_q        <= '0;
      ticks_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      next_block_q <= next_block_d;
      bytes_done_q <= bytes_done_d;
      awaiting_q   <= awaiting_d;
      collecting_q <= collecting_d;
      collected_q  <= collected_d;
      sum_q        <= sum_d;
      ticks_q      <= ticks_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_phase_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(awaiting_q && collecting_q))
    else $error("collecting and awaiting ack at once");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    collected_q <= LEN_W'(BLOCK_BYTES))
    else $error("block byte count past block size");

  a_header_arms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && emit && res.kind == KIND_HEADER) |=> awaiting_q && out_valid_q)
    else $error("header did not arm retransmit wait");

endmodule
`default_nettype wire

// ===== design/stop_and_wait_block_sender.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stop_and_wait_block_sender
// Stop-and-wait sender that cuts an image into blocks, checksums them and
// retransmits on timeout.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_stall_o / in_data_i; mode selects tick,
//                 acknowledgement, payload byte or start.
//   out channel : out_valid_o / out_stall_i / out_data_o; fetch requests,
//                 block headers, end header and final-ack notices.
//   APB port    : image size at 0x0, timeout in ticks at 0x4; write only
//                 while the block is idle.
//   Throughput is one request per cycle unless out_stall_i holds the
//   result register or the queue is full. A taken request passes the
//   command queue, then the execute stage, which owns all transfer
//   state, issues one command per cycle and registers its result.
//   When the receiver stalls, the result register holds; the queue still
//   takes up to two requests before in_stall_o rises.
//   Reset clears the transfer state, empties the queue and loads the
//   default image size and timeout.
// ----------------------------------------------------------------------------
module stop_and_wait_block_sender (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  input  sawbs_pkg::in_item_t               in_data_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  output sawbs_pkg::out_item_t              out_data_o,
  input  wire                               out_stall_i,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [sawbs_pkg::ADDR_W-1:0]       paddr,
  input  wire [sawbs_pkg::DATA_W-1:0]       pwdata,
  output logic [sawbs_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);
  import sawbs_pkg::*;

  logic [IMG_W-1:0]  image_q, image_d;
  logic [TICK_W-1:0] timeout_q, timeout_d;
  logic              cfg_wr;
  logic              q_full;
  logic              push;
  cmd_t              push_data;
  logic              q_valid;
  cmd_t              q_data;
  logic              q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    image_d   = image_q;
    timeout_d = timeout_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_IMAGE:   image_d   = pwdata[IMG_W-1:0];
        REG_TIMEOUT: timeout_d = pwdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE:   prdata = {{(DATA_W-IMG_W){1'b0}}, image_q};
      REG_TIMEOUT: prdata = {{(DATA_W-TICK_W){1'b0}}, timeout_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_q   <= IMAGE_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      image_q   <= image_d;
      timeout_q <= timeout_d;
    end
  end

  sawbs_front u_front (
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sawbs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_data),
    .pop_i       (q_pop)
  );

  sawbs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .image_bytes_i   (image_q),
    .timeout_ticks_i (timeout_q),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_data_o      (out_data_o),
    .out_stall_i     (out_stall_i)
  );

endmodule
`default_nettype wire
